>>> src/tbim_pkg.sv
// tbim_pkg: widths and shared types for the broadcast index mapper
// no dependencies; imported by the interfaces and every module of the block
package tbim_pkg;

  // width of one dimension size register
  localparam int SIZE_W     = 13;
  // width of the index fields on the input and output words
  localparam int IDX_W      = 32;
  // configuration channel widths
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;
  // quotient bits resolved by each divider stage (the last stage may resolve fewer)
  localparam int DIV_STEPS  = 4;

  typedef logic [SIZE_W-1:0] size_t;

endpackage

>>> src/tbim_if.sv
// tbim_if: valid/ready channel interfaces of the broadcast index mapper
// depends on tbim_pkg for the payload widths
interface tbim_in_if import tbim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;

  modport source (output valid, output out_index, input ready);
  modport sink   (input valid, input out_index, output ready);
endinterface

interface tbim_out_if import tbim_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] src_index;
  logic             index_valid;

  modport source (output valid, output src_index, output index_valid, input ready);
  modport sink   (input valid, input src_index, input index_valid, output ready);
endinterface

interface tbim_cfg_if import tbim_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/tensor_broadcast_index_map.sv
// tensor_broadcast_index_map: top level of the broadcast source index mapper
// depends on tbim_pkg, tbim_if, tbim_cfg and tbim_div
//
//   port    role    word                          handshake
//   in_i    sink    out_index                     valid / ready
//   out_o   source  src_index, index_valid        valid / ready
//   cfg_i   sink    index, data (register write)  valid / ready, ready always high
//
// one word enters per cycle, except while the output is stalled or the derived
// values are being rebuilt
// after any register write the input is held off while the element count and
// strides are rederived
// the whole pipeline advances together whenever the output register is free
// or being taken, so a stalled output holds every stage in place
// rst_ni clears all valid bits and loads sizes of 1 and an empty mask
module tensor_broadcast_index_map import tbim_pkg::*; #(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tbim_in_if.sink    in_i,
  tbim_out_if.source out_o,
  tbim_cfg_if.sink   cfg_i
);

  localparam int IB     = INDEX_BITS;
  localparam int WIDE_W = (IB > IDX_W) ? IB : IDX_W;
  localparam int SIDE_W = IB + 1;

  size_t           size_w   [MAX_DIMS];
  logic [IB-1:0]   stride_w [MAX_DIMS];
  logic [MAX_DIMS-1:0] bmask_w;
  logic [IB:0]     count_w;
  logic            busy_w;

  logic            en, accept, in_ok;
  logic [WIDE_W-1:0] idx_wide, src_wide;
  logic [IB-1:0]   idx;

  // boundaries between dimension slices, 0 is the input register
  logic            bnd_v   [MAX_DIMS+1];
  logic [IB-1:0]   bnd_rem [MAX_DIMS+1];
  logic [IB-1:0]   bnd_src [MAX_DIMS+1];
  logic            bnd_ok  [MAX_DIMS+1];

  logic            in_v_q;
  logic [IB-1:0]   in_rem_q;
  logic            in_ok_q;

  logic            out_v_q;
  logic [IDX_W-1:0] out_src_q;
  logic            out_ok_q;

  tbim_cfg #(
    .MAX_DIMS   (MAX_DIMS),
    .INDEX_BITS (IB)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .size_o   (size_w),
    .bmask_o  (bmask_w),
    .count_o  (count_w),
    .stride_o (stride_w),
    .busy_o   (busy_w)
  );

  // global advance and input handshake
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en && !busy_w;
  assign accept     = in_i.valid && in_i.ready;

  // range check against the element count
  assign idx_wide = WIDE_W'(in_i.out_index);
  assign idx      = idx_wide[IB-1:0];
  assign in_ok    = {1'b0, idx} < count_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (en) begin
      in_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_rem_q <= in_ok ? idx : '0;
      in_ok_q  <= in_ok;
    end
  end

  assign bnd_v[0]   = in_v_q;
  assign bnd_rem[0] = in_rem_q;
  assign bnd_src[0] = '0;
  assign bnd_ok[0]  = in_ok_q;

  // one slice per dimension, innermost first
  for (genvar p = 0; p < MAX_DIMS; p++) begin : g_dim
    localparam int DIM = MAX_DIMS - 1 - p;

    logic               dv;
    logic [IB-1:0]      dq;
    size_t              dr;
    logic [SIDE_W-1:0]  dside;
    logic [IB+SIZE_W-1:0] prod_full;

    logic               mv_q, mok_q;
    logic [IB-1:0]      mq_q, mprod_q, msrc_q;
    logic               av_q, aok_q;
    logic [IB-1:0]      arem_q, asrc_q;

    tbim_div #(
      .INDEX_BITS (IB),
      .SIDE_W     (SIDE_W)
    ) u_div (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (en),
      .valid_i    (bnd_v[p]),
      .dividend_i (bnd_rem[p]),
      .divisor_i  (size_w[DIM]),
      .side_i     ({bnd_ok[p], bnd_src[p]}),
      .valid_o    (dv),
      .quot_o     (dq),
      .rem_o      (dr),
      .side_o     (dside)
    );

    // coordinate times source stride, dropped for a broadcast dimension
    assign prod_full = dr * stride_w[DIM];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q <= 1'b0;
        av_q <= 1'b0;
      end else if (en) begin
        mv_q <= dv;
        av_q <= mv_q;
      end
    end

    // multiply stage, then accumulate stage
    always_ff @(posedge clk_i) begin
      if (en) begin
        mq_q    <= dq;
        mprod_q <= bmask_w[DIM] ? '0 : prod_full[IB-1:0];
        msrc_q  <= dside[IB-1:0];
        mok_q   <= dside[IB];
        arem_q  <= mq_q;
        asrc_q  <= msrc_q + mprod_q;
        aok_q   <= mok_q;
      end
    end

    assign bnd_v[p+1]   = av_q;
    assign bnd_rem[p+1] = arem_q;
    assign bnd_src[p+1] = asrc_q;
    assign bnd_ok[p+1]  = aok_q;
  end

  // output register
  assign src_wide = WIDE_W'(bnd_src[MAX_DIMS]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= bnd_v[MAX_DIMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_src_q <= bnd_ok[MAX_DIMS] ? src_wide[IDX_W-1:0] : '0;
      out_ok_q  <= bnd_ok[MAX_DIMS];
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.src_index   = out_src_q;
  assign out_o.index_valid = out_ok_q;

  // an out-of-range word always carries a zero index
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.index_valid |-> out_o.src_index == '0)
    else $error("invalid word with nonzero source index");

  // a held output freezes the pipeline, so no word may enter
  a_stall_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("input taken while output stalled");

  // derived values are rebuilt before the next word enters
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready |=> !in_i.ready)
    else $error("input taken during rederivation");

endmodule

>>> src/tbim_cfg.sv
// tbim_cfg: size and mask registers, plus a short sequencer that derives the
// element count and the source strides; depends on tbim_pkg and tbim_cfg_if
module tbim_cfg import tbim_pkg::*; #(
  parameter int MAX_DIMS   = 4,
  parameter int INDEX_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tbim_cfg_if.sink              cfg_i,
  output size_t                 size_o   [MAX_DIMS],
  output logic [MAX_DIMS-1:0]   bmask_o,
  output logic [INDEX_BITS:0]   count_o,
  output logic [INDEX_BITS-1:0] stride_o [MAX_DIMS],
  output logic                  busy_o
);

  localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W  = INDEX_BITS + 1;
  localparam int PROD_W = CNT_W + SIZE_W;
  localparam logic [PROD_W-1:0] CAP = {{SIZE_W{1'b0}}, 1'b1, {INDEX_BITS{1'b0}}};

  size_t                 size_q   [MAX_DIMS];
  logic [INDEX_BITS-1:0] stride_q [MAX_DIMS];
  logic [MAX_DIMS-1:0]   bmask_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [INDEX_BITS-1:0] acc_q, acc_d;
  logic                  busy_q;
  logic [DIM_W-1:0]      dim_q;
  logic                  wr;
  size_t                 size_cur;
  logic [PROD_W-1:0]     cnt_prod;
  logic [INDEX_BITS+SIZE_W-1:0] acc_prod;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // one dimension per cycle: saturating count and running stride
  assign size_cur = size_q[dim_q];
  assign cnt_prod = count_q * size_cur;
  assign acc_prod = acc_q * size_cur;
  assign count_d  = (cnt_prod > CAP) ? CAP[CNT_W-1:0] : cnt_prod[CNT_W-1:0];
  assign acc_d    = acc_prod[INDEX_BITS-1:0];

  // registers and derivation sequencer, restarted by every write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        size_q[d]   <= SIZE_W'(1);
        stride_q[d] <= INDEX_BITS'(1);
      end
      bmask_q <= '0;
      count_q <= CNT_W'(1);
      acc_q   <= INDEX_BITS'(1);
      busy_q  <= 1'b0;
      dim_q   <= '0;
    end else if (wr) begin
      if (cfg_i.index < CFG_ADDR_W'(MAX_DIMS)) begin
        size_q[cfg_i.index[DIM_W-1:0]] <= cfg_i.data[SIZE_W-1:0];
      end else if (cfg_i.index == CFG_ADDR_W'(MAX_DIMS)) begin
        bmask_q <= cfg_i.data[MAX_DIMS-1:0];
      end
      busy_q  <= 1'b1;
      dim_q   <= DIM_W'(MAX_DIMS - 1);
      count_q <= CNT_W'(1);
      acc_q   <= INDEX_BITS'(1);
    end else if (busy_q) begin
      stride_q[dim_q] <= acc_q;
      if (!bmask_q[dim_q]) begin
        acc_q <= acc_d;
      end
      count_q <= count_d;
      if (dim_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        dim_q <= dim_q - DIM_W'(1);
      end
    end
  end

  assign size_o   = size_q;
  assign stride_o = stride_q;
  assign bmask_o  = bmask_q;
  assign count_o  = count_q;
  assign busy_o   = busy_q;

  // count never passes the saturation value
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{SIZE_W{1'b0}}, count_q} <= CAP)
    else $error("element count above saturation value");

  // a write always starts a derivation pass
  a_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |=> busy_q)
    else $error("write did not start derivation");

  // element count holds once the pass is done
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q && !wr |=> $stable(count_q))
    else $error("element count moved while idle");

endmodule

>>> src/tbim_div.sv
// tbim_div: pipelined restoring divider, up to DIV_STEPS quotient bits a stage;
// divisor to be held static by the user (not enforced); depends on tbim_pkg
module tbim_div import tbim_pkg::*; #(
  parameter int INDEX_BITS = 32,
  parameter int SIDE_W     = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [INDEX_BITS-1:0] dividend_i,
  input  size_t                 divisor_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [INDEX_BITS-1:0] quot_o,
  output size_t                 rem_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int NSTG = (INDEX_BITS + DIV_STEPS - 1) / DIV_STEPS;

  logic [NSTG-1:0]       v_q;
  size_t                 r_q [NSTG];
  logic [INDEX_BITS-1:0] q_q [NSTG];
  logic [SIDE_W-1:0]     s_q [NSTG];

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    localparam int LEFT  = INDEX_BITS - g * DIV_STEPS;
    localparam int STEPS = (LEFT < DIV_STEPS) ? LEFT : DIV_STEPS;

    logic                  v_in;
    size_t                 r_in, r_d;
    logic [INDEX_BITS-1:0] q_in, q_d;
    logic [SIDE_W-1:0]     s_in;
    logic [SIZE_W:0]       t;

    if (g == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign q_in = dividend_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[g-1];
      assign r_in = r_q[g-1];
      assign q_in = q_q[g-1];
      assign s_in = s_q[g-1];
    end

    // shift one dividend bit in, subtract where the partial remainder allows
    always_comb begin
      r_d = r_in;
      q_d = q_in;
      t   = '0;
      for (int j = 0; j < STEPS; j++) begin
        t   = {r_d, q_d[INDEX_BITS-1]};
        q_d = {q_d[INDEX_BITS-2:0], 1'b0};
        if (t >= {1'b0, divisor_i}) begin
          t      = t - {1'b0, divisor_i};
          q_d[0] = 1'b1;
        end
        r_d = t[SIZE_W-1:0];
      end
    end

    // stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    // stage payload
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g] <= r_d;
        q_q[g] <= q_d;
        s_q[g] <= s_in;
      end
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign quot_o  = q_q[NSTG-1];
  assign rem_o   = r_q[NSTG-1];
  assign side_o  = s_q[NSTG-1];

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for tensor_broadcast_index_map, directed shapes then random ones
// depends on tbim_pkg, the channel interfaces in tbim_if and the block's top level
module tb;
  import tbim_pkg::*;

  localparam int          NDIMS        = 4;
  localparam int          LATENCY      = 2 + NDIMS * ((IDX_W + 3) / 4 + 2);
  localparam logic [63:0] IDX_SPAN     = 64'd1 << IDX_W;
  localparam int          LIMIT_CYCLES = 400000;
  localparam int          RANDOM_ITEMS = 1830;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIZE_DIM0,
    REG_SIZE_DIM1,
    REG_SIZE_DIM2,
    REG_SIZE_DIM3,
    REG_BCAST_MASK
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] src_index;
    logic             index_valid;
  } map_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tbim_in_if  in_if ();
  tbim_out_if out_if ();
  tbim_cfg_if cfg_if ();

  tensor_broadcast_index_map u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // shadow of the shape registers
  size_t          dim_size [NDIMS];
  logic [NDIMS-1:0] bcast_mask;

  map_word_t   pending_maps [$];
  map_word_t   want;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap_max  = 0;
  int unsigned rx_gap_max  = 0;

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t timeout with %0d words outstanding", $time, pending_maps.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output element count, saturating at the index span
  function automatic logic [63:0] element_total();
    logic [63:0] n;
    n = 64'd1;
    for (int d = 0; d < NDIMS; d++) n = n * dim_size[d];
    if (n > IDX_SPAN) n = IDX_SPAN;
    return n;
  endfunction

  // source index for one output index under the current shape
  function automatic map_word_t predict_src(logic [IDX_W-1:0] idx);
    map_word_t   w;
    logic [63:0] rem, coord, stride, src;
    w = '0;
    if (64'(idx) < element_total()) begin
      rem    = 64'(idx);
      stride = 64'd1;
      src    = 64'd0;
      // innermost dimension first; broadcast dimensions add no stride
      for (int d = NDIMS - 1; d >= 0; d--) begin
        coord = rem % dim_size[d];
        rem   = rem / dim_size[d];
        if (!bcast_mask[d]) begin
          src    = src + coord * stride;
          stride = stride * dim_size[d];
        end
      end
      w.src_index   = src[IDX_W-1:0];
      w.index_valid = 1'b1;
    end
    return w;
  endfunction

  // send one output index and queue its expected source index
  task automatic send_index(input logic [IDX_W-1:0] idx);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.out_index <= idx;
    do @(posedge clk_i); while (!in_if.ready);
    pending_maps.push_back(predict_src(idx));
  endtask

  // one register write, shadow updated on acceptance
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx < REG_BCAST_MASK) dim_size[idx[$clog2(NDIMS)-1:0]] = value[SIZE_W-1:0];
    else if (idx == REG_BCAST_MASK) bcast_mask = value[NDIMS-1:0];
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_shape(input logic [CFG_DATA_W-1:0] s0, s1, s2, s3, mask);
    write_reg(REG_SIZE_DIM0, s0);
    write_reg(REG_SIZE_DIM1, s1);
    write_reg(REG_SIZE_DIM2, s2);
    write_reg(REG_SIZE_DIM3, s3);
    write_reg(REG_BCAST_MASK, mask);
  endtask

  // hold the input until every queued word has come back
  task automatic wait_for_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_ADDR_W-1:0] spare_index();
    return CFG_ADDR_W'($urandom_range(REG_BCAST_MASK + 1, (1 << CFG_ADDR_W) - 1));
  endfunction

  // mostly small sizes so that valid indices are common
  function automatic logic [CFG_DATA_W-1:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 39);
    if (sel == 0) return '0;
    if (sel == 1) return CFG_DATA_W'($urandom_range(4097, (1 << CFG_DATA_W) - 1));
    if (sel == 2) return 4096;
    if (sel < 8) return CFG_DATA_W'($urandom_range(1, 4096));
    return CFG_DATA_W'($urandom_range(1, 12));
  endfunction

  // mostly in range, some at the boundary, some anywhere
  function automatic logic [IDX_W-1:0] pick_index(input logic [63:0] total);
    int unsigned sel;
    logic [63:0] v;
    sel = $urandom_range(0, 9);
    if (total == 0 || sel < 2) return $urandom;
    if (sel < 3) begin
      v = $urandom_range(0, 1) ? total - 1 : total;
      return v[IDX_W-1:0];
    end
    v = {$urandom, $urandom} % total;
    return v[IDX_W-1:0];
  endfunction

  task automatic pick_pacing();
    case ($urandom_range(0, 4))
      0: begin tx_gap_max = 0;  rx_gap_max = 0;  end
      1: begin tx_gap_max = 16; rx_gap_max = 0;  end
      2: begin tx_gap_max = 0;  rx_gap_max = 16; end
      3: begin tx_gap_max = 16; rx_gap_max = 16; end
      default: begin tx_gap_max = 4; rx_gap_max = 4; end
    endcase
  endtask

  // result side: random stall before taking each word
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = $urandom_range(0, rx_gap_max);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_maps.size() == 0) begin
        error_count++;
        $display("%0t unexpected word: expected none, actual src_index=%h index_valid=%b",
                 $time, out_if.src_index, out_if.index_valid);
      end else begin
        want = pending_maps.pop_front();
        if (out_if.src_index !== want.src_index) begin
          error_count++;
          $display("%0t src_index mismatch: expected %h, actual %h",
                   $time, want.src_index, out_if.src_index);
        end
        if (out_if.index_valid !== want.index_valid) begin
          error_count++;
          $display("%0t index_valid mismatch: expected %b, actual %b",
                   $time, want.index_valid, out_if.index_valid);
        end
      end
    end
  end

  // reset shape: a single element
  task automatic test_reset_state();
    send_index(0);
    send_index(1);
    send_index('1);
    wait_for_results();
  endtask

  // first, last, one past the last, an interior and the all-ones index of a 3x4x5x6 tensor
  task automatic test_shape_edges();
    set_shape(3, 4, 5, 6, 0);
    send_index(0);
    send_index(359);
    send_index(360);
    send_index(187);
    send_index('1);
    wait_for_results();
  endtask

  // mixed broadcast and full broadcast
  task automatic test_broadcast_masks();
    write_reg(REG_BCAST_MASK, 4'b1010);
    send_index(187);
    send_index(359);
    wait_for_results();
    write_reg(REG_BCAST_MASK, 4'b1111);
    send_index(359);
    wait_for_results();
  endtask

  // a zero size makes every index invalid
  task automatic test_zero_size();
    set_shape(2, 2, 0, 2, 0);
    send_index(0);
    send_index(3);
    wait_for_results();
  endtask

  // element count at and beyond the index span, and sizes above range
  task automatic test_count_saturation();
    set_shape(4096, 4096, 4096, 4096, 0);
    send_index(0);
    send_index('1);
    send_index(32'h8000_0000);
    wait_for_results();
    set_shape(4096, 4096, 256, 1, 4'b0101);
    send_index('1);
    wait_for_results();
    set_shape('1, '1, '1, '1, '1);
    send_index(32'hDEAD_BEEF);
    wait_for_results();
  endtask

  // writes beyond the mask register must leave the shape alone
  task automatic test_unused_registers();
    set_shape(5, 1, 7, 3, 4'b0010);
    write_reg(REG_BCAST_MASK + 1, '1);
    write_reg((1 << CFG_ADDR_W) - 1, '0);
    send_index(77);
    send_index(105);
    wait_for_results();
  endtask

  task automatic test_random_shapes();
    int unsigned           sent;
    int unsigned           n_items;
    logic [63:0]           total;
    logic [CFG_DATA_W-1:0] dims [NDIMS];
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      for (int d = 0; d < NDIMS; d++) dims[d] = pick_size();
      set_shape(dims[0], dims[1], dims[2], dims[3],
                CFG_DATA_W'($urandom_range(0, (1 << CFG_DATA_W) - 1)));
      if ($urandom_range(0, 3) == 0) write_reg(spare_index(), CFG_DATA_W'($urandom));
      pick_pacing();
      total   = element_total();
      n_items = $urandom_range(30, 90);
      repeat (n_items) send_index(pick_index(total));
      sent += n_items;
      wait_for_results();
    end
  endtask

  // main sequence
  initial begin
    in_if.valid     = 1'b0;
    in_if.out_index = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    for (int d = 0; d < NDIMS; d++) dim_size[d] = 1;
    bcast_mask = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    tx_gap_max = 3;
    rx_gap_max = 3;
    test_reset_state();
    test_shape_edges();
    test_broadcast_masks();
    test_zero_size();
    test_count_saturation();
    test_unused_registers();
    test_random_shapes();

    wait_for_results();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
